/* rtl/acwlf_pkg.sv */
// package for the associative write-back cache: sizes, commands, fsm states
// no dependencies
package acwlf_pkg;

  localparam int unsigned MemWords     = 1024;
  localparam int unsigned CacheLines   = 32;
  localparam int unsigned WordsPerLine = 4;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned AddrW  = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned LineOW = 5;
  localparam int unsigned WbW    = 3;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_PRELOAD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_TOUCH,
    ST_WB_RD,
    ST_WB_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_ACCESS,
    ST_RESULT
  } state_e;

endpackage

/* rtl/acwlf_mem.sv */
// generic single-port synchronous memory, registered read
// depends on nothing
module acwlf_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/acwlf_ctrl.sv */
// sequencer for the cache: tag search, lru update, write-back, fill, word access
// uses acwlf_pkg and two acwlf_mem instances for backing memory and line words
module acwlf_ctrl #(
  parameter int unsigned MEM_WORDS      = acwlf_pkg::MemWords,
  parameter int unsigned CACHE_LINES    = acwlf_pkg::CacheLines,
  parameter int unsigned WORDS_PER_LINE = acwlf_pkg::WordsPerLine
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          policy_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [acwlf_pkg::CmdW-1:0]    cmd_i,
  input  logic [acwlf_pkg::AddrW-1:0]   word_address_i,
  input  logic [acwlf_pkg::DataW-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acwlf_pkg::DataW-1:0]   read_data_o,
  output logic                          hit_o,
  output logic [acwlf_pkg::LineOW-1:0]  line_used_o,
  output logic [acwlf_pkg::WbW-1:0]     words_written_back_o
);
  import acwlf_pkg::*;

  // memory and line sizes are powers of two, addresses split into bit fields
  localparam int unsigned MemAW  = $clog2(MEM_WORDS);
  localparam int unsigned LineW  = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int unsigned OffB   = $clog2(WORDS_PER_LINE);
  localparam int unsigned OffW   = (OffB > 0) ? OffB : 1;
  localparam int unsigned BlockW = MemAW - OffB;
  localparam int unsigned CacheD = CACHE_LINES * WORDS_PER_LINE;
  localparam int unsigned CAW    = $clog2(CacheD);
  localparam int unsigned CwW    = DataW + 1;

  // memories; the top bit of a line word is its dirty flag
  logic             bm_we, cw_we;
  logic [MemAW-1:0] bm_addr;
  logic [DataW-1:0] bm_wdata, bm_rdata;
  logic [CAW-1:0]   cw_addr;
  logic [CwW-1:0]   cw_wdata, cw_rdata;

  acwlf_mem #(.Depth(MEM_WORDS), .Width(DataW)) u_backing (
    .clk_i, .we_i(bm_we), .addr_i(bm_addr), .wdata_i(bm_wdata), .rdata_o(bm_rdata));
  acwlf_mem #(.Depth(CacheD), .Width(CwW)) u_words (
    .clk_i, .we_i(cw_we), .addr_i(cw_addr), .wdata_i(cw_wdata), .rdata_o(cw_rdata));

  // tags, valid flags, lru order and round-robin pointer
  logic [BlockW-1:0]      tag_q [CACHE_LINES];
  logic [LineW-1:0]       order_q [CACHE_LINES];
  logic [LineW-1:0]       order_d [CACHE_LINES];
  logic [CACHE_LINES-1:0] valid_q, valid_d;
  logic [LineW-1:0]       fifo_q, fifo_d;
  logic                   tag_we;

  state_e            state_q, state_d;
  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [MemAW-1:0]  addr_q, addr_d;
  logic [DataW-1:0]  data_q, data_d;
  logic [LineW-1:0]  line_q, line_d;
  logic              hit_q, hit_d;
  logic [OffW-1:0]   w_q, w_d;
  logic [WbW-1:0]    wb_q, wb_d;
  logic              ovalid_q, ovalid_d;
  logic [DataW-1:0]  ord_q, ord_d;

  logic [BlockW-1:0] blk;
  logic [OffW-1:0]   off;
  logic [CAW-1:0]    base;
  logic [MemAW-1:0]  wb_a, fill_a;
  logic              match_found;
  logic [LineW-1:0]  match_line, order_pos;

  assign blk    = BlockW'(addr_q >> OffB);
  assign off    = OffW'(addr_q & MemAW'(WORDS_PER_LINE - 1));
  assign base   = CAW'(line_q) << OffB;
  assign wb_a   = (MemAW'(tag_q[line_q]) << OffB) | MemAW'(w_q);
  assign fill_a = (MemAW'(blk) << OffB) | MemAW'(w_q);

  // all tags compared at once, lowest matching line wins
  always_comb begin
    match_found = 1'b0;
    match_line  = '0;
    for (int i = int'(CACHE_LINES) - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == blk) begin
        match_found = 1'b1;
        match_line  = LineW'(i);
      end
    end
  end

  // position of the current line in the lru order
  always_comb begin
    order_pos = '0;
    for (int i = 0; i < int'(CACHE_LINES); i++) begin
      if (order_q[i] == line_q) order_pos = LineW'(i);
    end
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; addr_d = addr_q; data_d = data_q;
    line_d = line_q; hit_d = hit_q; w_d = w_q; wb_d = wb_q;
    valid_d = valid_q; fifo_d = fifo_q; order_d = order_q; tag_we = 1'b0;
    ovalid_d = ovalid_q; ord_d = ord_q;
    bm_we = 1'b0; bm_addr = addr_q; bm_wdata = data_q;
    cw_we = 1'b0; cw_addr = base | CAW'(w_q); cw_wdata = {1'b0, bm_rdata};
    in_ready_o = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !ovalid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_d = cmd_i; addr_d = MemAW'(word_address_i); data_d = write_data_i;
          hit_d = 1'b0; wb_d = '0; line_d = '0; w_d = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        case (cmd_e'(cmd_q)) inside
          CMD_READ, CMD_WRITE: begin
            if (match_found) begin
              hit_d = 1'b1; line_d = match_line;
            end else if (!(&valid_q) || policy_i) begin
              line_d = fifo_q;
              fifo_d = (fifo_q == LineW'(CACHE_LINES - 1)) ? '0 : fifo_q + LineW'(1);
            end else begin
              line_d = order_q[0];
            end
            state_d = ST_TOUCH;
          end
          CMD_PRELOAD: begin
            bm_we = 1'b1; ord_d = data_q; ovalid_d = 1'b1; state_d = ST_IDLE;
          end
          default: begin
            ord_d = '0; ovalid_d = 1'b1; state_d = ST_IDLE;
          end
        endcase
      end
      ST_TOUCH: begin
        // move the line to the most recent end of the order
        for (int i = 0; i < int'(CACHE_LINES) - 1; i++) begin
          if (i >= int'(order_pos)) order_d[i] = order_q[i+1];
        end
        order_d[CACHE_LINES-1] = line_q;
        if (hit_q) begin
          state_d = ST_ACCESS;
        end else if (valid_q[line_q]) begin
          state_d = ST_WB_RD;
        end else begin
          state_d = ST_FILL_RD;
        end
      end
      ST_WB_RD: begin
        state_d = ST_WB_WR;
      end
      ST_WB_WR: begin
        if (cw_rdata[DataW]) begin
          bm_we = 1'b1; bm_addr = wb_a; bm_wdata = cw_rdata[DataW-1:0];
          wb_d = (&wb_q) ? wb_q : wb_q + WbW'(1);
        end
        if (w_q == OffW'(WORDS_PER_LINE - 1)) begin
          w_d = '0; state_d = ST_FILL_RD;
        end else begin
          w_d = w_q + OffW'(1); state_d = ST_WB_RD;
        end
      end
      ST_FILL_RD: begin
        bm_addr = fill_a; state_d = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cw_we = 1'b1; cw_wdata = {1'b0, bm_rdata};
        if (w_q == OffW'(WORDS_PER_LINE - 1)) begin
          w_d = '0; tag_we = 1'b1; valid_d[line_q] = 1'b1; state_d = ST_ACCESS;
        end else begin
          w_d = w_q + OffW'(1); state_d = ST_FILL_RD;
        end
      end
      ST_ACCESS: begin
        cw_addr = base | CAW'(off);
        if (cmd_q == CMD_WRITE) begin
          cw_we = 1'b1; cw_wdata = {1'b1, data_q};
          ord_d = data_q; ovalid_d = 1'b1; state_d = ST_IDLE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        ord_d = cw_rdata[DataW-1:0]; ovalid_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; valid_q <= '0; fifo_q <= '0; ovalid_q <= 1'b0; w_q <= '0;
      for (int i = 0; i < int'(CACHE_LINES); i++) order_q[i] <= LineW'(i);
    end else begin
      state_q <= state_d; valid_q <= valid_d; fifo_q <= fifo_d; ovalid_q <= ovalid_d;
      w_q <= w_d; order_q <= order_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; addr_q <= addr_d; data_q <= data_d; line_q <= line_d;
    hit_q <= hit_d; wb_q <= wb_d; ord_q <= ord_d;
    if (tag_we) tag_q[line_q] <= blk;
  end

  assign out_valid_o          = ovalid_q;
  assign read_data_o          = ord_q;
  assign hit_o                = hit_q;
  assign line_used_o          = LineOW'(line_q);
  assign words_written_back_o = wb_q;

endmodule

/* rtl/assoc_cache_writeback_lru_fifo_top.sv */
// fully associative write-back cache, top level
// a preload or unused command is answered from the search state; a write hit passes search,
// lru touch and access, a read hit also a result state; a miss adds a fill of every line word
// and, for a valid victim, first a scan of every line word that writes dirty words back
// one transaction in flight, the next can be accepted in the same cycle the result is taken;
// async active-low reset clears valid flags, lru order, pointer and policy, not memories
module assoc_cache_writeback_lru_fifo_top #(
  parameter int unsigned MEM_WORDS      = acwlf_pkg::MemWords,
  parameter int unsigned CACHE_LINES    = acwlf_pkg::CacheLines,
  parameter int unsigned WORDS_PER_LINE = acwlf_pkg::WordsPerLine
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [acwlf_pkg::CmdW-1:0]    cmd_i,
  input  logic [acwlf_pkg::AddrW-1:0]   word_address_i,
  input  logic [acwlf_pkg::DataW-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acwlf_pkg::DataW-1:0]   read_data_o,
  output logic                          hit_o,
  output logic [acwlf_pkg::LineOW-1:0]  line_used_o,
  output logic [acwlf_pkg::WbW-1:0]     words_written_back_o
);

  logic policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  acwlf_ctrl #(
    .MEM_WORDS(MEM_WORDS), .CACHE_LINES(CACHE_LINES), .WORDS_PER_LINE(WORDS_PER_LINE)
  ) u_ctrl (
    .clk_i, .rst_ni, .policy_i(policy_q),
    .in_valid_i, .in_ready_o, .cmd_i, .word_address_i, .write_data_i,
    .out_valid_o, .out_ready_i, .read_data_o, .hit_o, .line_used_o,
    .words_written_back_o
  );

endmodule

/* rtl/acwlf_checker.sv */
// port-level checks for the cache top level, attached by bind
// depends on acwlf_pkg
module acwlf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [acwlf_pkg::DataW-1:0]   read_data_o,
  input logic                          hit_o,
  input logic [acwlf_pkg::WbW-1:0]     words_written_back_o
);
  import acwlf_pkg::*;

  // a hit never writes anything back
  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> words_written_back_o == '0)
    else $error("hit reported write-backs");

  // never more write-backs than words in a line
  a_wb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> words_written_back_o <= WbW'(WordsPerLine))
    else $error("too many write-backs");

  // an accepted transaction is never answered in the next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !(out_valid_o && !$past(out_valid_o)))
    else $error("result too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("result dropped while stalled");

endmodule

bind assoc_cache_writeback_lru_fifo_top acwlf_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .read_data_o, .hit_o, .words_written_back_o
);

/* tb/testbench.sv */
// self-checking testbench for the fully associative write-back cache top level
// depends on acwlf_pkg and assoc_cache_writeback_lru_fifo_top; the predictor and the
// scoreboard are a class local to this file
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acwlf_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]  rdata;
    logic              hit;
    logic [LineOW-1:0] line;
    logic [WbW-1:0]    wb;
  } cache_resp_t;

  class cache_scoreboard;
    logic [DataW-1:0]  mem [MemWords];
    bit                mem_known [MemWords];
    logic [DataW-1:0]  lwords [CacheLines*WordsPerLine];
    bit                dirty [CacheLines*WordsPerLine];
    logic [7:0]        tag [CacheLines];
    bit                lvalid [CacheLines];
    logic [LineOW-1:0] order [CacheLines];
    logic [LineOW-1:0] fifo_ptr;
    bit                policy_rr;
    cache_resp_t       pending [$];
    int                errors;
    int                checked;
    int                hits;
    int                evictions;

    function new();
      for (int i = 0; i < CacheLines; i++) begin
        lvalid[i] = 0;
        order[i]  = LineOW'(i);
      end
      for (int i = 0; i < CacheLines*WordsPerLine; i++) dirty[i] = 0;
      for (int i = 0; i < MemWords; i++) mem_known[i] = 0;
      fifo_ptr = '0;
      policy_rr = 0;
      errors = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
    endfunction

    function bit block_known(int blk);
      for (int i = 0; i < WordsPerLine; i++)
        if (!mem_known[blk*WordsPerLine+i]) return 0;
      return 1;
    endfunction

    function void touch_line(logic [LineOW-1:0] ln);
      int at;
      at = 0;
      for (int i = 0; i < CacheLines; i++) if (order[i] == ln) at = i;
      for (int i = at; i + 1 < CacheLines; i++) order[i] = order[i+1];
      order[CacheLines-1] = ln;
    endfunction

    function void note_request(cmd_e cmd, logic [AddrW-1:0] addr, logic [DataW-1:0] data);
      cache_resp_t r;
      int blk, off, ln, wb, k;
      bit full;
      r = '0;
      blk = addr / WordsPerLine;
      off = addr % WordsPerLine;
      if (cmd == CMD_PRELOAD) begin
        mem[addr] = data;
        mem_known[addr] = 1;
        r.rdata = data;
      end else if (cmd != CMD_NONE) begin
        ln = -1;
        wb = 0;
        for (int i = 0; i < CacheLines; i++)
          if (ln < 0 && lvalid[i] && tag[i] == blk) ln = i;
        r.hit = (ln >= 0);
        if (r.hit) begin
          hits++;
          touch_line(LineOW'(ln));
        end else begin
          full = 1;
          for (int i = 0; i < CacheLines; i++) if (!lvalid[i]) full = 0;
          if (!full || policy_rr) begin
            ln = fifo_ptr;
            fifo_ptr = fifo_ptr + 1'b1;
          end else begin
            ln = order[0];
          end
          touch_line(LineOW'(ln));
          if (lvalid[ln]) begin
            evictions++;
            for (int i = 0; i < WordsPerLine; i++) begin
              k = ln*WordsPerLine + i;
              if (dirty[k]) begin
                mem[tag[ln]*WordsPerLine+i] = lwords[k];
                mem_known[tag[ln]*WordsPerLine+i] = 1;
                wb++;
              end
            end
          end
          for (int i = 0; i < WordsPerLine; i++) begin
            k = ln*WordsPerLine + i;
            lwords[k] = mem[blk*WordsPerLine+i];
            dirty[k] = 0;
          end
          tag[ln] = 8'(blk);
          lvalid[ln] = 1;
        end
        k = ln*WordsPerLine + off;
        if (cmd == CMD_WRITE) begin
          lwords[k] = data;
          dirty[k] = 1;
        end
        r.rdata = lwords[k];
        r.line  = LineOW'(ln);
        r.wb    = WbW'((wb > 7) ? 7 : wb);
      end
      pending.push_back(r);
    endfunction

    function void check_response(cache_resp_t act);
      cache_resp_t exp;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected response %p", act);
        return;
      end
      exp = pending.pop_front();
      if (exp.rdata !== act.rdata || exp.hit !== act.hit || exp.line !== act.line ||
          exp.wb !== act.wb) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: rdata %h/%h hit %b/%b line %0d/%0d wb %0d/%0d (exp/act)",
                   exp.rdata, act.rdata, exp.hit, act.hit, exp.line, act.line,
                   exp.wb, act.wb);
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic              cfg_wdata_i = 0;
  logic              in_valid_i = 0;
  logic              in_ready_o;
  logic [CmdW-1:0]   cmd_i = '0;
  logic [AddrW-1:0]  word_address_i = '0;
  logic [DataW-1:0]  write_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 0;
  logic [DataW-1:0]  read_data_o;
  logic              hit_o;
  logic [LineOW-1:0] line_used_o;
  logic [WbW-1:0]    words_written_back_o;

  cache_scoreboard sb = new();
  bit allow_idle = 1;
  int stall_left = 0;
  int items_sent = 0;

  assoc_cache_writeback_lru_fifo_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .word_address_i, .write_data_i,
    .out_valid_o, .out_ready_i, .read_data_o, .hit_o, .line_used_o,
    .words_written_back_o
  );

  always #5 clk_i = ~clk_i;

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_response({read_data_o, hit_o, line_used_o, words_written_back_o});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  task automatic send_request(cmd_e cmd, logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1;
    cmd_i          <= cmd;
    word_address_i <= addr;
    write_data_i   <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, addr, data);
    items_sent++;
  endtask

  task automatic set_policy(bit rr);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= rr;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.policy_rr = rr;
  endtask

  // hot blocks give hits and evictions, the rest spreads the address bits
  task automatic random_requests(int n);
    int blk, pick;
    logic [AddrW-1:0] addr;
    for (int j = 0; j < n; j++) begin
      blk = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 47) : $urandom_range(0, 255);
      addr = AddrW'(blk*WordsPerLine + $urandom_range(0, WordsPerLine-1));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(CMD_NONE, AddrW'($urandom), $urandom);
      end else if (pick < 12) begin
        send_request(CMD_PRELOAD, addr, $urandom);
      end else if (!sb.block_known(blk)) begin
        // never fill a line from backing words that were never written
        for (int i = 0; i < WordsPerLine; i++)
          if (!sb.mem_known[blk*WordsPerLine+i]) addr = AddrW'(blk*WordsPerLine + i);
        send_request(CMD_PRELOAD, addr, $urandom);
      end else begin
        send_request(pick < 56 ? CMD_READ : CMD_WRITE, addr, $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_policy(0);
    for (int i = 0; i < WordsPerLine; i++) begin
      send_request(CMD_PRELOAD, AddrW'(i), i[0] ? 32'hFFFF_FFFF : 32'h0);
      send_request(CMD_PRELOAD, AddrW'(MemWords - WordsPerLine + i), 32'hA5A5_0000 + i);
    end
    send_request(CMD_READ, '0, '0);
    send_request(CMD_WRITE, AddrW'(1), 32'h0);
    send_request(CMD_READ, AddrW'(1), '1);
    send_request(CMD_WRITE, AddrW'(MemWords-1), 32'hFFFF_FFFF);
    send_request(CMD_READ, AddrW'(MemWords-1), '0);
    // preload of a cached word leaves the cached copy alone
    send_request(CMD_PRELOAD, AddrW'(1), 32'h1234_5678);
    send_request(CMD_READ, AddrW'(1), '0);
    send_request(CMD_NONE, '1, '1);
    send_request(CMD_NONE, '0, '0);
    random_requests(500);
    set_policy(1);
    random_requests(450);
    set_policy(0);
    random_requests(400);
    set_policy(1);
    allow_idle = 0;
    random_requests(280);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d transactions, %0d hits, %0d evictions, both replacement policies",
             items_sent, sb.hits, sb.evictions);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS assoc_cache_writeback_lru_fifo_top");
    end else begin
      $display("%0d mismatches, %0d responses outstanding", sb.errors, sb.pending.size());
      $display("FAIL assoc_cache_writeback_lru_fifo_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAIL assoc_cache_writeback_lru_fifo_top");
    $finish;
  end
endmodule
